[rtl/spq_pkg.sv]
// ============================================================================
// Sorted priority queue package
// Shared types, operation codes and status codes for the queue cell chain.
// ============================================================================
package spq_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 32;
    localparam int COUNT_W  = $clog2(DEPTH + 1);

    localparam logic [1:0] FUNC_FRONT  = 2'd0;
    localparam logic [1:0] FUNC_SORTED = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_NOP    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] entry_key;
        logic [7:0]  entry_tag;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        head_valid;
        logic [31:0] head_key;
        logic [7:0]  head_tag;
        logic [4:0]  entry_count;
    } result_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [7:0]          tag;
    } slot_t;

    typedef struct packed {
        logic       en;
        logic [1:0] func;
        slot_t      item;
    } cell_ctl_t;

endpackage

[rtl/spq_cell.sv]
// ============================================================================
// Queue cell
// Holds one slot of the queue and decides each operation from its neighbors.
// ============================================================================
module spq_cell (
    input  logic              clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic              occupied,
    input  spq_pkg::slot_t    left_entry,
    input  spq_pkg::slot_t    right_entry,
    input  logic              keep_in,
    input  logic              hit_in,
    output spq_pkg::slot_t    entry,
    output logic              keep_out,
    output logic              hit_out
);
    import spq_pkg::*;

    slot_t entry_reg;
    slot_t entry_next;
    logic  goes_after;
    logic  match;

    assign goes_after = occupied && (ctl.func == FUNC_SORTED) && (ctl.item.key >= entry_reg.key);
    assign keep_out   = keep_in & goes_after;
    assign match      = occupied && (entry_reg.tag == ctl.item.tag);
    assign hit_out    = hit_in | match;
    assign entry      = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.en)
        begin
            unique case (ctl.func)
                FUNC_FRONT, FUNC_SORTED:
                begin
                    if (keep_out)
                        entry_next = entry_reg;
                    else if (keep_in)
                        entry_next = ctl.item;
                    else
                        entry_next = left_entry;
                end
                FUNC_REMOVE:
                begin
                    if (hit_out)
                        entry_next = right_entry;
                end
                FUNC_NOP:
                begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

[rtl/sorted_priority_queue.sv]
// Sequence: an accepted start loads cmd_reg and moves state_reg to EXEC, raising
// busy; done_reg is then set from the EXEC state and presents the result.
// Busy is high for the one cycle in which the whole cell row compares and shifts
// in parallel; no new command is taken while busy.
// Reset clears the entry count and control state at once; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ============================================================================
// Sorted priority queue
// Shift-register ordered queue of key and tag entries built from a cell row.
// ============================================================================
module sorted_priority_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  spq_pkg::cmd_t    cmd,
    output logic             done,
    output spq_pkg::result_t result
);
    import spq_pkg::*;

    localparam logic STATE_IDLE = 1'b0;
    localparam logic STATE_EXEC = 1'b1;

    logic               state_reg;
    logic               state_next;
    cmd_t               cmd_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic               done_reg;

    logic               is_insert;
    logic               is_full;
    logic               refused;
    cell_ctl_t          ctl;
    slot_t              cell_entry [DEPTH];
    logic [DEPTH:0]     keep_chain;
    logic [DEPTH:0]     hit_chain;

    assign is_insert = (cmd_reg.func == FUNC_FRONT) || (cmd_reg.func == FUNC_SORTED);
    assign is_full   = (count_reg == COUNT_W'(DEPTH));
    assign refused   = is_insert && is_full;

    assign ctl.en       = (state_reg == STATE_EXEC) && !refused;
    assign ctl.func     = cmd_reg.func;
    assign ctl.item.key = KEY_BITS'(cmd_reg.entry_key);
    assign ctl.item.tag = cmd_reg.entry_tag;

    assign keep_chain[0] = 1'b1;
    assign hit_chain[0]  = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        slot_t left_entry;
        slot_t right_entry;
        logic  occupied;

        assign occupied = (count_reg > COUNT_W'(i));

        if (i == 0)
        begin : g_first
            assign left_entry = ctl.item;
        end
        else
        begin : g_mid
            assign left_entry = cell_entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .occupied   (occupied),
            .left_entry (left_entry),
            .right_entry(right_entry),
            .keep_in    (keep_chain[i]),
            .hit_in     (hit_chain[i]),
            .entry      (cell_entry[i]),
            .keep_out   (keep_chain[i+1]),
            .hit_out    (hit_chain[i+1])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = status_reg;
        unique case (state_reg)
            STATE_IDLE:
            begin
                if (start)
                    state_next = STATE_EXEC;
            end
            STATE_EXEC:
            begin
                state_next  = STATE_IDLE;
                status_next = ST_OK;
                if (is_insert)
                begin
                    if (is_full)
                        status_next = ST_FULL;
                    else
                        count_next = count_reg + COUNT_W'(1);
                end
                else if (cmd_reg.func == FUNC_REMOVE)
                begin
                    if (hit_chain[DEPTH])
                        count_next = count_reg - COUNT_W'(1);
                    else
                        status_next = ST_NOT_FOUND;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == STATE_EXEC);
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (start && (state_reg == STATE_IDLE))
            cmd_reg <= cmd;
    end

    assign busy = (state_reg == STATE_EXEC);
    assign done = done_reg;

    assign result.status      = status_reg;
    assign result.head_valid  = (count_reg != '0);
    assign result.head_key    = (count_reg != '0) ? 32'(cell_entry[0].key) : '0;
    assign result.head_tag    = (count_reg != '0) ? cell_entry[0].tag : '0;
    assign result.entry_count = 5'(count_reg);

endmodule

[rtl/spq_checker.sv]
// ============================================================================
// Sorted priority queue checker
// Port-level assertions on the command handshake and result consistency.
// ============================================================================
module spq_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input spq_pkg::cmd_t    cmd,
    input logic             done,
    input spq_pkg::result_t result
);
    import spq_pkg::*;

    logic [4:0] cmd_tag_low;

    assign cmd_tag_low = cmd.entry_tag[4:0];

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted transfer did not raise busy.");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("Busy cycle was not followed by a result.");

    a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.head_valid == (result.entry_count != 5'd0)))
        else $error("Head valid disagrees with entry count.");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_FULL)) |-> (result.entry_count == 5'(DEPTH)))
        else $error("Full status reported on a queue that is not full.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.entry_count <= 5'(DEPTH)) || (cmd_tag_low != cmd_tag_low)))
        else $error("Entry count exceeds the queue depth.");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

[test/tb_sorted_priority_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// Sorted priority queue testbench
// Sends queue commands over the start/busy handshake. Each command is run
// through a behavioral copy of the queue. The result transfers are then
// checked field by field against the expected results, oldest first. A short
// table of directed commands comes first. It is followed by random fill and
// drain phases, with the sender idling in bursts.
// ============================================================================
module tb_sorted_priority_queue;

    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct {
        cmd_t    cmd;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;

    logic [KEY_BITS-1:0] held_keys [DEPTH];
    logic [7:0]          held_tags [DEPTH];
    int                  held_count;

    result_t   pending_results [$];
    stim_row_t directed_rows [$];

    int error_count;
    int cycle_count;
    int burst_left;
    int front_count;
    int sorted_count;
    int remove_count;
    int nop_count;
    int full_count;
    int missing_count;
    int peak_count;

    sorted_priority_queue dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sorted_priority_queue test failed");
            $finish;
        end
    end

    function automatic stim_row_t plain_row(logic [1:0] func, logic [31:0] key,
                                            logic [7:0] tag);
        stim_row_t r;
        r.cmd   = '{func: func, entry_key: key, entry_tag: tag};
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic stim_row_t known_row(logic [1:0] func, logic [31:0] key,
                                            logic [7:0] tag, logic [1:0] status,
                                            logic hv, logic [31:0] hkey,
                                            logic [7:0] htag, logic [4:0] cnt);
        stim_row_t r;
        r       = plain_row(func, key, tag);
        r.typed = 1'b1;
        r.want  = '{status: status, head_valid: hv, head_key: hkey,
                    head_tag: htag, entry_count: cnt};
        return r;
    endfunction

    task automatic apply_cmd(input cmd_t c, output result_t r);
        int pos;
        int i;
        int hit;
        r        = '0;
        r.status = ST_OK;
        case (c.func)
            FUNC_FRONT, FUNC_SORTED:
            begin
                if (held_count >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    pos = 0;
                    if (c.func == FUNC_SORTED)
                    begin
                        while (pos < held_count && c.entry_key >= held_keys[pos])
                        begin
                            pos++;
                        end
                    end
                    for (i = held_count; i > pos; i--)
                    begin
                        held_keys[i] = held_keys[i - 1];
                        held_tags[i] = held_tags[i - 1];
                    end
                    held_keys[pos] = c.entry_key;
                    held_tags[pos] = c.entry_tag;
                    held_count++;
                end
            end
            FUNC_REMOVE:
            begin
                hit = -1;
                for (i = 0; i < held_count && hit < 0; i++)
                begin
                    if (held_tags[i] == c.entry_tag)
                    begin
                        hit = i;
                    end
                end
                if (hit < 0)
                begin
                    r.status = ST_NOT_FOUND;
                end
                else
                begin
                    for (i = hit; i + 1 < held_count; i++)
                    begin
                        held_keys[i] = held_keys[i + 1];
                        held_tags[i] = held_tags[i + 1];
                    end
                    held_count--;
                end
            end
            default:
            begin
            end
        endcase
        if (held_count > 0)
        begin
            r.head_valid = 1'b1;
            r.head_key   = held_keys[0];
            r.head_tag   = held_tags[0];
        end
        r.entry_count = held_count[4:0];
    endtask

    task automatic issue(input cmd_t c, input bit typed, input result_t want);
        result_t predicted;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy !== 1'b0)
        begin
            @(posedge clk);
        end
        apply_cmd(c, predicted);
        pending_results.push_back(typed ? want : predicted);
        case (c.func)
            FUNC_FRONT:  front_count++;
            FUNC_SORTED: sorted_count++;
            FUNC_REMOVE: remove_count++;
            default:     nop_count++;
        endcase
        if (predicted.status == ST_FULL)
        begin
            full_count++;
        end
        if (predicted.status == ST_NOT_FOUND)
        begin
            missing_count++;
        end
        if (held_count > peak_count)
        begin
            peak_count = held_count;
        end
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap   = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(result.status));
                check_field("head_valid", 32'(want.head_valid), 32'(result.head_valid));
                check_field("head_key", want.head_key, result.head_key);
                check_field("head_tag", 32'(want.head_tag), 32'(result.head_tag));
                check_field("entry_count", 32'(want.entry_count),
                            32'(result.entry_count));
            end
        end
    end

    initial
    begin : stimulus
        cmd_t c;
        int   n;
        int   roll;
        int   phase_left;
        bit   filling;

        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        held_count  = 0;
        error_count = 0;
        cycle_count = 0;
        burst_left  = 0;

        directed_rows.push_back(known_row(FUNC_REMOVE, 32'h0, 8'h00,
                                          ST_NOT_FOUND, 1'b0, 32'h0, 8'h00, 5'd0));
        directed_rows.push_back(known_row(FUNC_NOP, 32'h12345678, 8'h5A,
                                          ST_OK, 1'b0, 32'h0, 8'h00, 5'd0));
        directed_rows.push_back(known_row(FUNC_FRONT, 32'hFFFFFFFF, 8'hFF,
                                          ST_OK, 1'b1, 32'hFFFFFFFF, 8'hFF, 5'd1));
        directed_rows.push_back(known_row(FUNC_SORTED, 32'h0, 8'h00,
                                          ST_OK, 1'b1, 32'h0, 8'h00, 5'd2));
        directed_rows.push_back(plain_row(FUNC_SORTED, 32'hFFFFFFFF, 8'h01));
        directed_rows.push_back(plain_row(FUNC_SORTED, 32'h0, 8'h02));
        directed_rows.push_back(known_row(FUNC_FRONT, 32'h5, 8'h03,
                                          ST_OK, 1'b1, 32'h5, 8'h03, 5'd5));
        directed_rows.push_back(known_row(FUNC_FRONT, 32'h7, 8'h03,
                                          ST_OK, 1'b1, 32'h7, 8'h03, 5'd6));
        directed_rows.push_back(known_row(FUNC_REMOVE, 32'h0, 8'h03,
                                          ST_OK, 1'b1, 32'h5, 8'h03, 5'd5));
        directed_rows.push_back(plain_row(FUNC_REMOVE, 32'h0, 8'hFF));
        directed_rows.push_back(plain_row(FUNC_NOP, 32'hDEADBEEF, 8'hC3));
        directed_rows.push_back(plain_row(FUNC_SORTED, 32'hAAAAAAAA, 8'h55));
        directed_rows.push_back(plain_row(FUNC_SORTED, 32'h55555555, 8'hAA));
        directed_rows.push_back(plain_row(FUNC_SORTED, 32'h80000000, 8'h80));
        directed_rows.push_back(plain_row(FUNC_SORTED, 32'h7FFFFFFF, 8'h7F));
        directed_rows.push_back(plain_row(FUNC_SORTED, 32'h00000001, 8'h10));
        directed_rows.push_back(plain_row(FUNC_SORTED, 32'hFFFFFFFE, 8'h11));
        directed_rows.push_back(plain_row(FUNC_SORTED, 32'h0, 8'h12));
        directed_rows.push_back(plain_row(FUNC_SORTED, 32'h5, 8'h13));
        directed_rows.push_back(plain_row(FUNC_SORTED, 32'h0000FFFF, 8'h14));
        directed_rows.push_back(plain_row(FUNC_SORTED, 32'hFFFF0000, 8'h15));
        directed_rows.push_back(plain_row(FUNC_SORTED, 32'h12345678, 8'h16));
        directed_rows.push_back(plain_row(FUNC_SORTED, 32'hFFFFFFFF, 8'h17));
        directed_rows.push_back(plain_row(FUNC_SORTED, 32'h3, 8'h20));
        directed_rows.push_back(plain_row(FUNC_FRONT, 32'h9, 8'h21));
        directed_rows.push_back(plain_row(FUNC_REMOVE, 32'h0, 8'hEE));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            issue(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
            pace();
        end

        filling    = 1'b1;
        phase_left = $urandom_range(20, 60);
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                filling    = !filling;
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            roll        = $urandom_range(0, 99);
            c.entry_key = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15);
            c.entry_tag = $urandom_range(0, 255);
            if (roll < 5)
            begin
                c.func = FUNC_NOP;
            end
            else if (roll < (filling ? 75 : 25))
            begin
                c.func = ($urandom_range(0, 3) == 0) ? FUNC_FRONT : FUNC_SORTED;
            end
            else
            begin
                c.func = FUNC_REMOVE;
                if (held_count > 0 && $urandom_range(0, 9) != 0)
                begin
                    c.entry_tag = held_tags[$urandom_range(0, held_count - 1)];
                end
            end
            issue(c, 1'b0, '0);
            pace();
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d transfers: %0d front, %0d sorted, %0d remove, %0d unused code.",
                 front_count + sorted_count + remove_count + nop_count,
                 front_count, sorted_count, remove_count, nop_count);
        $display("Saw %0d refused inserts, %0d missing tags, peak occupancy %0d.",
                 full_count, missing_count, peak_count);
        if (error_count == 0)
        begin
            $display("sorted_priority_queue test passed");
        end
        else
        begin
            $display("sorted_priority_queue test failed");
        end
        $finish;
    end

endmodule

[sorted_priority_queue.f]
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
test/tb_sorted_priority_queue.sv
